[rtl/small_matrix_add_sub_mul_macros.svh]
// Assertion helpers used by the RTL
`ifndef SMALL_MATRIX_ADD_SUB_MUL_MACROS_SVH
`define SMALL_MATRIX_ADD_SUB_MUL_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SMAS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SMAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/smas_pkg.sv]
`default_nettype none
package smas_pkg;

  // matrix size default
  localparam int DIM_DEFAULT = 3;

  // field widths
  localparam int ELEM_W  = 16;
  localparam int PROD_W  = 32;
  localparam int VALUE_W = 33;
  localparam int IDX_W   = 2;
  localparam int MODE_W  = 2;

  // op_mode codes; the unused code behaves as add
  localparam logic [MODE_W-1:0] OP_ADD = 2'd0;
  localparam logic [MODE_W-1:0] OP_SUB = 2'd1;
  localparam logic [MODE_W-1:0] OP_MUL = 2'd2;

  // sequencer states
  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  // per-lane control from the sequencer
  typedef struct packed {
    logic wr;   // an input word is written this cycle
    logic adv;  // pipeline advances this cycle
  } lane_ctrl_t;

endpackage
`default_nettype wire

[rtl/smas_ram.sv]
`default_nettype none
module smas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 3
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[rtl/smas_lane.sv]
`default_nettype none
// One lane k: holds column k of A and row k of B, forms A[r][k] * B[k][c].
module smas_lane #(
  parameter int DIM  = smas_pkg::DIM_DEFAULT,
  parameter int LANE = 0
) (
  input  wire logic                              clk,
  input  wire smas_pkg::lane_ctrl_t              ctrl,
  input  wire logic [$clog2(DIM)-1:0]            ld_row,
  input  wire logic [$clog2(DIM)-1:0]            ld_col,
  input  wire logic [smas_pkg::ELEM_W-1:0]       a_elem,
  input  wire logic [smas_pkg::ELEM_W-1:0]       b_elem,
  input  wire logic [$clog2(DIM)-1:0]            rd_row,
  input  wire logic [$clog2(DIM)-1:0]            rd_col,
  output      logic signed [smas_pkg::ELEM_W-1:0] a_r,
  output      logic signed [smas_pkg::ELEM_W-1:0] b_r,
  output      logic signed [smas_pkg::PROD_W-1:0] prod_r
);

  localparam int IW = $clog2(DIM);
  localparam logic [IW-1:0] MY_IDX = IW'(LANE);

  logic                        we_a;
  logic                        we_b;
  logic [smas_pkg::ELEM_W-1:0] a_q;
  logic [smas_pkg::ELEM_W-1:0] b_q;

  // A[row][col] lands in lane col at address row; B[row][col] in lane row at col
  assign we_a = ctrl.wr && (ld_col == MY_IDX);
  assign we_b = ctrl.wr && (ld_row == MY_IDX);

  smas_ram #(.WIDTH(smas_pkg::ELEM_W), .DEPTH(DIM)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (ld_row),
    .wdata (a_elem),
    .re    (ctrl.adv),
    .raddr (rd_row),
    .rdata (a_q)
  );

  smas_ram #(.WIDTH(smas_pkg::ELEM_W), .DEPTH(DIM)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (ld_col),
    .wdata (b_elem),
    .re    (ctrl.adv),
    .raddr (rd_col),
    .rdata (b_q)
  );

  // product stage; operands kept for the element-wise modes
  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      a_r    <= $signed(a_q);
      b_r    <= $signed(b_q);
      prod_r <= $signed(a_q) * $signed(b_q);
    end
  end

endmodule
`default_nettype wire

[rtl/smas_merge.sv]
`default_nettype none
// Combines the lanes: sum of products, or one A and one B element.
module smas_merge #(
  parameter int DIM = smas_pkg::DIM_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               adv,
  input  wire logic [smas_pkg::MODE_W-1:0]        mode,
  input  wire logic [$clog2(DIM)-1:0]             row,
  input  wire logic [$clog2(DIM)-1:0]             col,
  input  wire logic signed [smas_pkg::ELEM_W-1:0] lane_a [DIM],
  input  wire logic signed [smas_pkg::ELEM_W-1:0] lane_b [DIM],
  input  wire logic signed [smas_pkg::PROD_W-1:0] lane_p [DIM],
  output      logic [smas_pkg::VALUE_W-1:0]       value_r
);

  logic signed [smas_pkg::VALUE_W-1:0] dot;
  logic signed [smas_pkg::VALUE_W-1:0] a_ext;
  logic signed [smas_pkg::VALUE_W-1:0] b_ext;
  logic [smas_pkg::VALUE_W-1:0]        value_nxt;

  // sum of the lane products, wraps modulo 2^33
  always_comb begin
    dot = '0;
    for (int k = 0; k < DIM; k++) begin
      dot = dot + smas_pkg::VALUE_W'(lane_p[k]);
    end
  end

  // A[r][c] sits in lane c, B[r][c] in lane r
  assign a_ext = smas_pkg::VALUE_W'(lane_a[col]);
  assign b_ext = smas_pkg::VALUE_W'(lane_b[row]);

  always_comb begin
    case (mode)
      smas_pkg::OP_MUL: value_nxt = dot;
      smas_pkg::OP_SUB: value_nxt = a_ext - b_ext;
      default:          value_nxt = a_ext + b_ext;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      value_r <= value_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/small_matrix_add_sub_mul.sv]
// Loading: one element pair per cycle; DIM*DIM words load both matrices.
// After the completing word, DIM*DIM results leave one per cycle; the first is
// valid after lane RAM read, lane multiply and merge. Input is held off
// while the DIM*DIM results are issued; output stalls freeze the whole pipeline.
// Reset (rst_n low, synchronous) clears the load position, the sequencer,
// the valid flags and op_mode; matrix RAMs are not cleared.
`default_nettype none
`include "small_matrix_add_sub_mul_macros.svh"
module small_matrix_add_sub_mul #(
  parameter int DIM = smas_pkg::DIM_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: op_mode
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_data,
  // input words
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [31:0] in_tdata,   // a_elem[15:0], b_elem[31:16]
  // result words
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [39:0] out_tdata,  // result_value[32:0], result_row[34:33],
                                       // result_col[36:35], zero pad[39:37]
  output      logic        out_tlast   // result_last
);

  localparam int IW = $clog2(DIM);
  localparam logic [IW-1:0] LAST_IDX = IW'(DIM - 1);

  smas_pkg::state_t state_r, state_nxt;
  smas_pkg::lane_ctrl_t ctrl;

  logic [smas_pkg::MODE_W-1:0] op_mode_r;
  logic [smas_pkg::MODE_W-1:0] mode_r;
  logic [IW-1:0] ld_row_r, ld_col_r;
  logic [IW-1:0] is_row_r, is_col_r;

  logic in_fire;
  logic load_done;
  logic issue_last;
  logic adv;
  logic issue;

  // pipeline stage 1 (RAM read) and stage 2 (lane products)
  logic                        v1_r, v2_r;
  logic [IW-1:0]               row1_r, col1_r, row2_r, col2_r;
  logic [smas_pkg::MODE_W-1:0] mode1_r, mode2_r;
  logic                        last1_r, last2_r;

  // output register
  logic                         out_tvalid_r;
  logic                         out_tlast_r;
  logic [IW-1:0]                out_row_r, out_col_r;
  logic [smas_pkg::VALUE_W-1:0] value_r;
  logic [IW+1:0]                row_ext, col_ext;

  logic signed [smas_pkg::ELEM_W-1:0] lane_a [DIM];
  logic signed [smas_pkg::ELEM_W-1:0] lane_b [DIM];
  logic signed [smas_pkg::PROD_W-1:0] lane_p [DIM];

  assign in_fire    = in_tvalid && in_tready;
  assign load_done  = in_fire && (ld_row_r == LAST_IDX) && (ld_col_r == LAST_IDX);
  assign issue_last = (is_row_r == LAST_IDX) && (is_col_r == LAST_IDX);
  assign adv        = !out_tvalid_r || out_tready;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r <= smas_pkg::OP_ADD;
    end else if (cfg_valid) begin
      op_mode_r <= cfg_data;
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      smas_pkg::ST_LOAD: begin
        if (load_done) state_nxt = smas_pkg::ST_EMIT;
      end
      smas_pkg::ST_EMIT: begin
        if (issue && issue_last) state_nxt = smas_pkg::ST_LOAD;
      end
      default: state_nxt = smas_pkg::ST_LOAD;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    issue     = 1'b0;
    case (state_r)
      smas_pkg::ST_LOAD: in_tready = 1'b1;
      smas_pkg::ST_EMIT: issue     = adv;
      default: begin
        in_tready = 1'b0;
        issue     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smas_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // load position and issue position, row-major
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_row_r <= '0;
      ld_col_r <= '0;
      is_row_r <= '0;
      is_col_r <= '0;
    end else begin
      if (in_fire) begin
        if (ld_col_r == LAST_IDX) begin
          ld_col_r <= '0;
          ld_row_r <= (ld_row_r == LAST_IDX) ? '0 : ld_row_r + 1'b1;
        end else begin
          ld_col_r <= ld_col_r + 1'b1;
        end
      end
      if (issue) begin
        if (is_col_r == LAST_IDX) begin
          is_col_r <= '0;
          is_row_r <= (is_row_r == LAST_IDX) ? '0 : is_row_r + 1'b1;
        end else begin
          is_col_r <= is_col_r + 1'b1;
        end
      end
    end
  end

  // mode is taken on the completing word
  always_ff @(posedge clk) begin
    if (load_done) begin
      mode_r <= op_mode_r;
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      v1_r         <= issue;
      v2_r         <= v1_r;
      out_tvalid_r <= v2_r;
    end
  end

  // pipeline tags
  always_ff @(posedge clk) begin
    if (adv) begin
      row1_r      <= is_row_r;
      col1_r      <= is_col_r;
      mode1_r     <= mode_r;
      last1_r     <= issue_last;
      row2_r      <= row1_r;
      col2_r      <= col1_r;
      mode2_r     <= mode1_r;
      last2_r     <= last1_r;
      out_row_r   <= row2_r;
      out_col_r   <= col2_r;
      out_tlast_r <= last2_r;
    end
  end

  assign ctrl.wr  = in_fire;
  assign ctrl.adv = adv;

  // one lane per inner-product term
  for (genvar k = 0; k < DIM; k++) begin : g_lane
    smas_lane #(.DIM(DIM), .LANE(k)) u_lane (
      .clk    (clk),
      .ctrl   (ctrl),
      .ld_row (ld_row_r),
      .ld_col (ld_col_r),
      .a_elem (in_tdata[15:0]),
      .b_elem (in_tdata[31:16]),
      .rd_row (is_row_r),
      .rd_col (is_col_r),
      .a_r    (lane_a[k]),
      .b_r    (lane_b[k]),
      .prod_r (lane_p[k])
    );
  end

  smas_merge #(.DIM(DIM)) u_merge (
    .clk     (clk),
    .adv     (adv),
    .mode    (mode2_r),
    .row     (row2_r),
    .col     (col2_r),
    .lane_a  (lane_a),
    .lane_b  (lane_b),
    .lane_p  (lane_p),
    .value_r (value_r)
  );

  // row and column keep their low two bits
  assign row_ext = {2'b00, out_row_r};
  assign col_ext = {2'b00, out_col_r};

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_tlast_r;
  assign out_tdata  = {3'b000, col_ext[smas_pkg::IDX_W-1:0],
                       row_ext[smas_pkg::IDX_W-1:0], value_r};

  // checks
  `SMAS_ASSERT_NEXT(a_emit_start, load_done,
    (state_r == smas_pkg::ST_EMIT) && (is_row_r == '0) && (is_col_r == '0),
    "emit did not start at element zero")
  `SMAS_ASSERT_NEXT(a_stall_holds, out_tvalid && !out_tready,
    $stable(v1_r) && $stable(v2_r) && $stable(is_row_r) && $stable(is_col_r),
    "pipeline moved during output stall")
  `SMAS_ASSERT_NOW(a_last_pos, out_tvalid && out_tlast,
    (out_row_r == LAST_IDX) && (out_col_r == LAST_IDX),
    "last marker away from final element")
  `SMAS_ASSERT_NOW(a_no_load_in_emit, issue, !in_fire,
    "input accepted while results are issued")

endmodule
`default_nettype wire
